// File: rtl/core/fed_pkg.sv
// ----------------------------------------------------------------------------
// fed_pkg
// Shared widths, reset values, register indexes and saturation helper of the
// feedback echo delay line.
// ----------------------------------------------------------------------------
`default_nettype none

package fed_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam int DEF_MAX_DELAY_DEPTH = 65536;
    localparam int DEF_CHANNELS        = 2;

    localparam logic [15:0] DELAY_RESET    = 16'd11025;
    localparam logic [15:0] FEEDBACK_RESET = 16'd16384;
    localparam logic [15:0] DAMPING_RESET  = 16'd29491;

    // 1.0 in Q1.15
    localparam logic [15:0] UNITY_Q15 = 16'h8000;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELAY    = 2'd0,
        REG_FEEDBACK = 2'd1,
        REG_DAMPING  = 2'd2
    } t_reg_idx;

    function automatic t_sample sat16(input logic signed [23:0] a);
        if (a > 24'sd32767) begin
            return 16'sh7fff;
        end else if (a < -24'sd32768) begin
            return 16'sh8000;
        end else begin
            return a[15:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/fed_in_if.sv
// ----------------------------------------------------------------------------
// fed_in_if
// Input sample channel: valid/ready handshake with one sample per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface fed_in_if;
    logic                               valid;
    logic                               ready;
    logic                               channel;
    logic signed [fed_pkg::SAMPLE_W-1:0] sample_in;
    logic                               sample_present;
    logic signed [fed_pkg::SAMPLE_W-1:0] mod_in;
    logic                               mod_present;
    logic                               frame_end;

    modport source (
        output valid, channel, sample_in, sample_present, mod_in, mod_present, frame_end,
        input  ready
    );

    modport sink (
        input  valid, channel, sample_in, sample_present, mod_in, mod_present, frame_end,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/fed_out_if.sv
// ----------------------------------------------------------------------------
// fed_out_if
// Output sample channel: valid/ready handshake with one echo sample per
// transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface fed_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [fed_pkg::SAMPLE_W-1:0] sample_out;
    logic                               out_channel;

    modport source (
        output valid, sample_out, out_channel,
        input  ready
    );

    modport sink (
        input  valid, sample_out, out_channel,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/fed_ring_store.sv
// ----------------------------------------------------------------------------
// fed_ring_store
// Echo ring memory with one registered read port, one write port and a
// zeroing sweep that runs after reset and on request.
// ----------------------------------------------------------------------------
`default_nettype none

module fed_ring_store #(
    parameter  int DEPTH  = fed_pkg::DEF_MAX_DELAY_DEPTH * fed_pkg::DEF_CHANNELS,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_clr_start,
    output logic                       o_clr_busy,
    input  wire logic                  i_rd_en,
    input  wire logic [ADDR_W-1:0]     i_rd_addr,
    output fed_pkg::t_sample           o_rd_data,
    input  wire logic                  i_wr_en,
    input  wire logic [ADDR_W-1:0]     i_wr_addr,
    input  wire fed_pkg::t_sample      i_wr_data
);

    fed_pkg::t_sample mem [DEPTH];

    logic              r_busy;
    logic [ADDR_W-1:0] r_clr_addr;
    fed_pkg::t_sample  r_rd_data;

    logic              w_we;
    logic [ADDR_W-1:0] w_wa;
    fed_pkg::t_sample  w_wd;

    always_comb begin
        if (r_busy) begin
            w_we = 1'b1;
            w_wa = r_clr_addr;
            w_wd = '0;
        end else begin
            w_we = i_wr_en;
            w_wa = i_wr_addr;
            w_wd = i_wr_data;
        end
    end

    // zeroing sweep, one entry per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (i_clr_start) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_wa] <= w_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_clr_busy = r_busy;
    assign o_rd_data  = r_rd_data;

endmodule

`default_nettype wire

// File: rtl/core/feedback_echo_delay_line.sv
// ----------------------------------------------------------------------------
// feedback_echo_delay_line
// Multi-channel feedback echo with a damped (one-pole lowpass) feedback path.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries one Q1.15 sample per transaction, tagged with its channel;
//   frame_end on the last channel of a frame advances the shared ring
//   position. o_out returns one saturated echo sample per input transaction,
//   in input order, with the channel it was computed for.
//   Each sample does one read-modify-write of its ring entry: the ring read
//   and the feedback factor multiply at acceptance, the entry times factor
//   multiply, the output rounding, then the lowpass and write back. The
//   result goes to the output register at write-back, and a new sample is
//   taken only once all four sequencer steps of the last one are done.
//   The output register lets the next sample enter while a result waits; a
//   stalled receiver holds the block only at its write-back step.
//   Configuration goes through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
//   After reset, and after a write that changes delay_samples, the ring is
//   zeroed (MAX_DELAY_DEPTH * CHANNELS entries, 131072 by default) and no
//   sample is taken meanwhile. Reset also clears position and lowpass state.
// ----------------------------------------------------------------------------
`default_nettype none

module feedback_echo_delay_line #(
    parameter int MAX_DELAY_DEPTH = fed_pkg::DEF_MAX_DELAY_DEPTH,
    parameter int CHANNELS        = fed_pkg::DEF_CHANNELS
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [fed_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [fed_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    fed_in_if.sink                               i_in,
    fed_out_if.source                            o_out
);

    localparam int POS_W  = $clog2(MAX_DELAY_DEPTH);
    localparam int DEPTH  = MAX_DELAY_DEPTH * CHANNELS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CMP_W  = (POS_W + 1 > 16) ? POS_W + 1 : 16;
    localparam logic [CMP_W-1:0] DLY_MAX = CMP_W'(MAX_DELAY_DEPTH - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_V,
        S_WB
    } t_state;

    // configuration
    logic [15:0]        r_delay;
    logic signed [15:0] r_fb;
    logic [15:0]        r_damp;

    // control and state
    t_state             r_state;
    logic [POS_W:0]     r_pos;
    fed_pkg::t_sample   r_lp [CHANNELS];
    logic               r_out_valid;
    fed_pkg::t_sample   r_out_sample;
    logic               r_out_ch;

    // per-item payload
    logic [CH_W-1:0]    r_ch;
    logic [POS_W-1:0]   r_pos_used;
    logic               r_frame_end;
    logic [ADDR_W-1:0]  r_addr;
    fed_pkg::t_sample   r_x;
    logic signed [31:0] r_factor;
    logic signed [47:0] r_prod;
    fed_pkg::t_sample   r_v;

    logic               w_clr_busy;
    logic               w_clr_start;
    fed_pkg::t_sample   w_entry;
    logic               w_accept;
    logic               w_wb_go;

    logic [CMP_W-1:0]   w_eff_dly;
    logic [POS_W-1:0]   w_pos_used;
    logic [CH_W-1:0]    w_ch;
    logic [ADDR_W-1:0]  w_rd_addr;
    logic [15:0]        w_mod_off;
    logic signed [32:0] w_factor;
    logic signed [47:0] w_prod;
    logic signed [48:0] w_t;
    logic signed [18:0] w_v_rnd;
    logic [15:0]        w_h;
    logic signed [16:0] w_diff;
    logic signed [33:0] w_dh;
    logic signed [34:0] w_s;
    fed_pkg::t_sample   w_y;
    logic [POS_W:0]     n_pos;

    assign w_accept = i_in.valid && i_in.ready;
    assign w_wb_go  = (r_state == S_WB) && (!r_out_valid || o_out.ready);

    // effective delay and position used by this transaction
    always_comb begin
        w_eff_dly  = (CMP_W'(r_delay) > DLY_MAX) ? DLY_MAX : CMP_W'(r_delay);
        w_pos_used = (CMP_W'(r_pos) > w_eff_dly) ? '0 : r_pos[POS_W-1:0];
        w_ch       = ({31'b0, i_in.channel} >= 32'(CHANNELS)) ? CH_W'(CHANNELS - 1)
                                                              : CH_W'(i_in.channel);
        w_rd_addr  = ADDR_W'(w_pos_used) * ADDR_W'(CHANNELS) + ADDR_W'(w_ch);
    end

    // fb * 32768 + fb * mod = fb * (mod + 32768); mod + 32768 is offset binary
    assign w_mod_off = i_in.mod_present ? {~i_in.mod_in[15], i_in.mod_in[14:0]}
                                        : fed_pkg::UNITY_Q15;
    assign w_factor  = r_fb * $signed({1'b0, w_mod_off});

    assign w_prod = w_entry * r_factor;

    // v = round((x * 2^30 - entry * F) / 2^30)
    assign w_t     = $signed({{3{r_x[15]}}, r_x, 30'b0}) - $signed({r_prod[47], r_prod})
                     + $signed(49'd1 << 29);
    assign w_v_rnd = w_t[48:30];

    // lowpass as old + (v - old) * h, same value as v*h + old*(1 - h)
    assign w_h    = (r_damp > fed_pkg::UNITY_Q15) ? fed_pkg::UNITY_Q15 : r_damp;
    assign w_diff = $signed({r_v[15], r_v}) - $signed({r_lp[r_ch][15], r_lp[r_ch]});
    assign w_dh   = w_diff * $signed({1'b0, w_h});
    assign w_s    = $signed({{4{r_lp[r_ch][15]}}, r_lp[r_ch], 15'b0})
                    + $signed({w_dh[33], w_dh}) + $signed(35'd1 << 14);
    assign w_y    = fed_pkg::sat16({{4{w_s[34]}}, w_s[34:15]});

    assign n_pos = r_frame_end ? ((POS_W + 1)'(r_pos_used) + 1'b1) : r_pos;

    assign w_clr_start = i_cfg_we && (i_cfg_idx == fed_pkg::REG_DELAY)
                         && (i_cfg_data != r_delay);

    fed_ring_store #(
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clr_start (w_clr_start),
        .o_clr_busy  (w_clr_busy),
        .i_rd_en     (w_accept),
        .i_rd_addr   (w_rd_addr),
        .o_rd_data   (w_entry),
        .i_wr_en     (w_wb_go),
        .i_wr_addr   (r_addr),
        .i_wr_data   (w_y)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= fed_pkg::DELAY_RESET;
            r_fb    <= fed_pkg::FEEDBACK_RESET;
            r_damp  <= fed_pkg::DAMPING_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fed_pkg::REG_DELAY:    r_delay <= i_cfg_data;
                fed_pkg::REG_FEEDBACK: r_fb    <= i_cfg_data;
                fed_pkg::REG_DAMPING:  r_damp  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // sequencer with output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_lp[i] <= '0;
            end
        end else begin
            if (w_wb_go) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_ch        <= w_ch;
                        r_pos_used  <= w_pos_used;
                        r_frame_end <= i_in.frame_end;
                        r_addr      <= w_rd_addr;
                        r_x         <= i_in.sample_present ? i_in.sample_in : '0;
                        r_factor    <= w_factor[31:0];
                        r_state     <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_V;
                end
                S_V: begin
                    r_v     <= fed_pkg::sat16({{5{w_v_rnd[18]}}, w_v_rnd});
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (w_wb_go) begin
                        r_lp[r_ch]   <= w_y;
                        r_pos        <= n_pos;
                        r_out_sample <= r_v;
                        r_out_ch     <= r_ch[0];
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE) && !w_clr_busy;
    assign o_out.valid       = r_out_valid;
    assign o_out.sample_out  = r_out_sample;
    assign o_out.out_channel = r_out_ch;

endmodule

`default_nettype wire

// File: test/tb_feedback_echo_delay_line.sv
// ----------------------------------------------------------------------------
// tb_feedback_echo_delay_line
// Self-checking bench for the feedback echo delay line: random and directed
// samples go in over the input channel, a bit-true model of the ring, the
// damped feedback path and the position logic predicts every echo sample,
// and each output transaction is compared in order. The run steps through
// several register settings and idle/stall patterns on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_feedback_echo_delay_line;

    localparam int DEPTH  = fed_pkg::DEF_MAX_DELAY_DEPTH;
    localparam int LANES  = fed_pkg::DEF_CHANNELS;
    localparam logic [fed_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic             channel;
        fed_pkg::t_sample smp;
        logic             smp_on;
        fed_pkg::t_sample mod;
        logic             mod_on;
        logic             frame_end;
        logic             drain;
    } t_item;

    typedef struct {
        fed_pkg::t_sample level;
        logic             lane;
    } t_echo;

    logic                           i_clk;
    logic                           i_rst_n    = 1'b0;
    logic                           i_cfg_we   = 1'b0;
    logic [fed_pkg::CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [fed_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    fed_in_if  in_ch ();
    fed_out_if out_ch ();

    feedback_echo_delay_line dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // model state
    fed_pkg::t_sample   ring_mem [0:DEPTH*LANES-1];
    fed_pkg::t_sample   lp_mem   [0:LANES-1];
    int unsigned        ring_pos;
    logic [15:0]        delay_reg;
    logic signed [15:0] fb_reg;
    logic [15:0]        damp_reg;

    t_item sample_q[$];
    t_echo echo_q[$];
    t_item on_wire;
    t_echo due_echo;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int samples_queued = 0;
    int samples_taken  = 0;
    int echoes_seen    = 0;
    int cfg_writes     = 0;
    int err_count      = 0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("feedback_echo_delay_line test failed");
        $finish;
    end

    function automatic longint round_q(input longint a, input int s);
        return (a + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clip16(input longint a);
        if (a > 32767) begin
            return 32767;
        end else if (a < -32768) begin
            return -32768;
        end
        return a;
    endfunction

    // one sample through the ring, feedback and lowpass
    function automatic void run_echo(input t_item s);
        int unsigned lane;
        int unsigned pos;
        int unsigned span;
        longint      h, x, fb, factor, entry, v, y;
        lane = s.channel;
        if (lane >= LANES) lane = LANES - 1;
        span = delay_reg;
        if (span > DEPTH - 1) span = DEPTH - 1;
        pos = ring_pos;
        if (pos > span) pos = 0;
        h = (damp_reg > fed_pkg::UNITY_Q15) ? longint'(fed_pkg::UNITY_Q15)
                                            : longint'(damp_reg);
        x = s.smp_on ? longint'(s.smp) : 0;
        fb = fb_reg;
        factor = fb * 32768;
        if (s.mod_on) factor += fb * longint'(s.mod);
        entry = ring_mem[pos * LANES + lane];
        v = clip16(round_q((x <<< 30) - entry * factor, 30));
        y = clip16(round_q(v * h + longint'(lp_mem[lane]) * (32768 - h), 15));
        ring_mem[pos * LANES + lane] = y[15:0];
        lp_mem[lane] = y[15:0];
        if (s.frame_end) ring_pos = pos + 1;
        echo_q.push_back('{level: v[15:0], lane: lane[0]});
    endfunction

    task automatic log_error(input string msg);
        err_count++;
        if (err_count <= 10) $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic fed_pkg::t_sample pick_level();
        case ($urandom_range(9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return fed_pkg::t_sample'($signed($urandom_range(64)) - 32);
            default: return fed_pkg::t_sample'($urandom);
        endcase
    endfunction

    function automatic t_item make_sample(input logic ch, input logic fe);
        t_item s;
        s.channel   = ch;
        s.smp       = pick_level();
        s.smp_on    = ($urandom_range(99) < 85);
        s.mod       = pick_level();
        s.mod_on    = $urandom_range(1);
        s.frame_end = fe;
        s.drain     = 1'b0;
        return s;
    endfunction

    task automatic push_sample(input t_item s);
        sample_q.push_back(s);
        samples_queued++;
    endtask

    task automatic add_sample(input logic ch, input fed_pkg::t_sample smp, input logic sp,
                              input fed_pkg::t_sample mod, input logic mp, input logic fe);
        push_sample('{channel: ch, smp: smp, smp_on: sp, mod: mod, mod_on: mp,
                      frame_end: fe, drain: 1'b0});
    endtask

    // mostly well-formed stereo frames, some loose transactions
    task automatic queue_random(input int count, input int drain_at);
        t_item s;
        int    k;
        k = 0;
        while (k < count) begin
            if ($urandom_range(99) < 85) begin
                s = make_sample(1'b0, 1'b0);
                s.drain = (k == drain_at) || (k + 1 == drain_at);
                push_sample(s);
                push_sample(make_sample(1'b1, 1'b1));
                k += 2;
            end else begin
                s = make_sample($urandom_range(1), $urandom_range(1));
                s.drain = (k == drain_at);
                push_sample(s);
                k++;
            end
        end
    endtask

    task automatic write_reg(input logic [fed_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_writes++;
        case (idx)
            fed_pkg::REG_DELAY: begin
                if (val != delay_reg) begin
                    foreach (ring_mem[k]) ring_mem[k] = '0;
                end
                delay_reg = val;
            end
            fed_pkg::REG_FEEDBACK: fb_reg = val;
            fed_pkg::REG_DAMPING:  damp_reg = val;
            default: ;
        endcase
    endtask

    // wait until every queued sample has come back, then let the pipe go quiet
    task automatic settle();
        while (sample_q.size() != 0 || samples_taken != samples_queued
               || echo_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                run_echo(on_wire);
                samples_taken++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (sample_q.size() != 0 && !(sample_q[0].drain && echo_q.size() != 0)
                    && $urandom_range(99) >= send_idle_pct) begin
                    on_wire = sample_q.pop_front();
                    in_ch.channel        <= on_wire.channel;
                    in_ch.sample_in      <= on_wire.smp;
                    in_ch.sample_present <= on_wire.smp_on;
                    in_ch.mod_in         <= on_wire.mod;
                    in_ch.mod_present    <= on_wire.mod_on;
                    in_ch.frame_end      <= on_wire.frame_end;
                    in_ch.valid          <= 1'b1;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                echoes_seen++;
                if (echo_q.size() == 0) begin
                    log_error($sformatf("echo sample %0d ch %0d with nothing due",
                                        out_ch.sample_out, out_ch.out_channel));
                end else begin
                    due_echo = echo_q.pop_front();
                    if (out_ch.sample_out !== due_echo.level) begin
                        log_error($sformatf("sample_out: expected %0d, got %0d",
                                            due_echo.level, out_ch.sample_out));
                    end
                    if (out_ch.out_channel !== due_echo.lane) begin
                        log_error($sformatf("out_channel: expected %0d, got %0d",
                                            due_echo.lane, out_ch.out_channel));
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin
        in_ch.valid          = 1'b0;
        in_ch.channel        = 1'b0;
        in_ch.sample_in      = '0;
        in_ch.sample_present = 1'b0;
        in_ch.mod_in         = '0;
        in_ch.mod_present    = 1'b0;
        in_ch.frame_end      = 1'b0;
        out_ch.ready         = 1'b0;

        foreach (ring_mem[k]) ring_mem[k] = '0;
        foreach (lp_mem[k]) lp_mem[k] = '0;
        ring_pos  = 0;
        delay_reg = fed_pkg::DELAY_RESET;
        fb_reg    = fed_pkg::FEEDBACK_RESET;
        damp_reg  = fed_pkg::DAMPING_RESET;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // ring clear after reset holds ready low
        while (!in_ch.ready) @(posedge i_clk);

        // single-entry ring, unity feedback and no damping: every sample sees the last
        write_reg(fed_pkg::REG_FEEDBACK, 16'h7fff);
        write_reg(fed_pkg::REG_DAMPING, fed_pkg::UNITY_Q15);
        write_reg(fed_pkg::REG_DELAY, 16'd0);
        add_sample(1'b0, 16'sh7fff, 1'b1, 16'sh0000, 1'b0, 1'b0);
        add_sample(1'b1, 16'sh8000, 1'b1, 16'sh0000, 1'b0, 1'b1);
        add_sample(1'b0, 16'sh8000, 1'b1, 16'sh0000, 1'b0, 1'b0);
        add_sample(1'b1, 16'sh7fff, 1'b1, 16'sh0000, 1'b0, 1'b1);
        add_sample(1'b0, 16'sh7fff, 1'b0, 16'sh0000, 1'b0, 1'b0);
        add_sample(1'b1, 16'sh8000, 1'b0, 16'sh0000, 1'b0, 1'b1);
        add_sample(1'b0, 16'sd1000, 1'b1, 16'sh8000, 1'b1, 1'b0);
        add_sample(1'b1, 16'sd1000, 1'b1, 16'sh7fff, 1'b1, 1'b1);
        add_sample(1'b0, 16'shffff, 1'b1, 16'sh7fff, 1'b0, 1'b0);
        add_sample(1'b1, 16'sh0000, 1'b1, 16'sh8000, 1'b1, 1'b1);
        add_sample(1'b0, 16'sh0000, 1'b0, 16'sh0000, 1'b0, 1'b1);
        add_sample(1'b0, 16'sd12345, 1'b1, 16'sh0000, 1'b0, 1'b1);
        add_sample(1'b1, -16'sd12345, 1'b1, -16'sd16384, 1'b1, 1'b0);
        add_sample(1'b1, 16'sh7fff, 1'b1, 16'sh7fff, 1'b1, 1'b1);
        add_sample(1'b1, 16'sh8000, 1'b1, 16'shffff, 1'b1, 1'b1);
        add_sample(1'b0, 16'sh8000, 1'b1, 16'sh8000, 1'b1, 1'b0);
        add_sample(1'b1, 16'sh5555, 1'b1, 16'shaaaa, 1'b1, 1'b0);
        add_sample(1'b0, 16'shaaaa, 1'b1, 16'sh5555, 1'b1, 1'b1);
        settle();

        // same delay again keeps the ring; lowpass frozen by zero damping
        write_reg(fed_pkg::REG_FEEDBACK, 16'h8000);
        write_reg(fed_pkg::REG_DAMPING, 16'd0);
        write_reg(REG_UNUSED, 16'hffff);
        write_reg(fed_pkg::REG_DELAY, 16'd0);
        send_idle_pct = 68;
        queue_random(260, -1);
        settle();

        write_reg(fed_pkg::REG_FEEDBACK, -16'sd20000);
        write_reg(fed_pkg::REG_DAMPING, 16'hffff);
        write_reg(fed_pkg::REG_DELAY, 16'd40);
        send_idle_pct  = 0;
        recv_stall_pct = 68;
        queue_random(460, 230);
        settle();

        // shrinking the ring usually leaves the position past the new end
        write_reg(fed_pkg::REG_FEEDBACK, 16'd24000);
        write_reg(fed_pkg::REG_DAMPING, 16'd20000);
        write_reg(fed_pkg::REG_DELAY, 16'd3);
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        queue_random(460, 100);
        settle();

        write_reg(fed_pkg::REG_FEEDBACK, 16'h7fff);
        write_reg(fed_pkg::REG_DAMPING, 16'd16384);
        write_reg(fed_pkg::REG_DELAY, 16'hffff);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random(450, -1);
        settle();

        $display("ran %0d samples through 5 settings: ring length 1 to 65536,", samples_taken);
        $display("feedback and damping extremes, %0d echo samples compared, %0d reg writes",
                 echoes_seen, cfg_writes);
        if (err_count == 0) begin
            $display("feedback_echo_delay_line test passed");
        end else begin
            $display("feedback_echo_delay_line test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
